>>> rtl/core/scancode_set1_to_ascii_decoder_core_macros.svh
// assertion macros shared by the scancode decoder checkers
// no dependencies; included by the checker file
`ifndef SCANCODE_SET1_TO_ASCII_DECODER_CORE_MACROS_SVH
`define SCANCODE_SET1_TO_ASCII_DECODER_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define SC1_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define SC1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sc1_pkg.sv
// types, codes and key tables of the scancode set 1 decoder
// no dependencies; imported by the decode, core and checker files
`default_nettype none

package sc1_pkg;

  // scancode bytes with a meaning of their own
  localparam logic [7:0] ScExtPrefix  = 8'hE0;
  localparam logic [6:0] ScLShift     = 7'h2A;
  localparam logic [6:0] ScRShift     = 7'h36;
  localparam logic [6:0] ScCtrl       = 7'h1D;
  localparam logic [6:0] ScAlt        = 7'h38;
  localparam logic [6:0] ScCapsLock   = 7'h3A;
  localparam logic [6:0] ScCursorUp   = 7'h48;
  localparam logic [6:0] ScCursorDown = 7'h50;

  // system-request keys
  localparam logic [6:0] ScSysDiag     = 7'h58;
  localparam logic [6:0] ScSysIrq      = 7'h17;
  localparam logic [6:0] ScSysKill     = 7'h25;
  localparam logic [6:0] ScSysReboot   = 7'h30;
  localparam logic [6:0] ScSysPowerOff = 7'h18;

  // system-request action codes
  localparam logic [6:0] ActDiag     = 7'd0;
  localparam logic [6:0] ActIrq      = 7'd1;
  localparam logic [6:0] ActKill     = 7'd2;
  localparam logic [6:0] ActReboot   = 7'd3;
  localparam logic [6:0] ActPowerOff = 7'd4;

  localparam logic [6:0] AsciiLowerA = 7'h61;
  localparam logic [6:0] AsciiLowerZ = 7'h7A;
  localparam logic [6:0] AsciiCaseBit = 7'h20;

  typedef enum logic [1:0] {
    EVT_CHAR      = 2'd0,
    EVT_CUR_UP    = 2'd1,
    EVT_CUR_DOWN  = 2'd2,
    EVT_SYSREQ    = 2'd3
  } evt_kind_e;

  // modifier and prefix state
  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
    logic ext;
  } mod_state_t;

  // one decoded result
  typedef struct packed {
    logic      valid;
    evt_kind_e kind;
    logic [6:0] code;
  } dec_res_t;

  // unshifted us layout, zero where the key has no character
  function automatic logic [7:0] plain_char(input logic [6:0] key);
    logic [7:0] c;
    case (key)
      7'h0E: c = 8'd8;
      7'h0F: c = 8'd9;
      7'h1C: c = 8'd10;
      7'h29: c = 8'h60; // grave accent
      7'h02: c = "1";
      7'h03: c = "2";
      7'h04: c = "3";
      7'h05: c = "4";
      7'h06: c = "5";
      7'h07: c = "6";
      7'h08: c = "7";
      7'h09: c = "8";
      7'h0A: c = "9";
      7'h0B: c = "0";
      7'h0C: c = "-";
      7'h0D: c = "=";
      7'h10: c = "q";
      7'h11: c = "w";
      7'h12: c = "e";
      7'h13: c = "r";
      7'h14: c = "t";
      7'h15: c = "y";
      7'h16: c = "u";
      7'h17: c = "i";
      7'h18: c = "o";
      7'h19: c = "p";
      7'h1A: c = "[";
      7'h1B: c = "]";
      7'h1E: c = "a";
      7'h1F: c = "s";
      7'h20: c = "d";
      7'h21: c = "f";
      7'h22: c = "g";
      7'h23: c = "h";
      7'h24: c = "j";
      7'h25: c = "k";
      7'h26: c = "l";
      7'h27: c = ";";
      7'h28: c = "'";
      7'h2B: c = "\\";
      7'h2C: c = "z";
      7'h2D: c = "x";
      7'h2E: c = "c";
      7'h2F: c = "v";
      7'h30: c = "b";
      7'h31: c = "n";
      7'h32: c = "m";
      7'h33: c = ",";
      7'h34: c = ".";
      7'h35: c = "/";
      7'h39: c = " ";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // shifted us layout for keys that are not letters
  function automatic logic [7:0] shift_char(input logic [6:0] key);
    logic [7:0] c;
    case (key)
      7'h0E: c = 8'd8;
      7'h0F: c = 8'd9;
      7'h1C: c = 8'd10;
      7'h29: c = "~";
      7'h02: c = "!";
      7'h03: c = "@";
      7'h04: c = "#";
      7'h05: c = "$";
      7'h06: c = "%";
      7'h07: c = "^";
      7'h08: c = "&";
      7'h09: c = "*";
      7'h0A: c = "(";
      7'h0B: c = ")";
      7'h0C: c = "_";
      7'h0D: c = "+";
      7'h1A: c = "{";
      7'h1B: c = "}";
      7'h27: c = ":";
      7'h28: c = "\"";
      7'h2B: c = "|";
      7'h33: c = "<";
      7'h34: c = ">";
      7'h35: c = "?";
      7'h39: c = " ";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sc1_byte_if.sv
// valid/ready channel that carries one scancode byte per item
// no dependencies
`default_nettype none

interface sc1_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sc1_event_if.sv
// valid/ready channel that carries one decoded key event per item
// no dependencies
`default_nettype none

interface sc1_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [6:0] event_code;

  modport source (output valid, output event_kind, output event_code, input ready);
  modport sink   (input valid, input event_kind, input event_code, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sc1_decode.sv
// combinational decode of one scancode byte against the modifier state
// depends on sc1_pkg
`default_nettype none

module sc1_decode (
  input  logic [7:0]         scan_byte_i,
  input  sc1_pkg::mod_state_t state_i,
  output sc1_pkg::mod_state_t state_o,
  output sc1_pkg::dec_res_t   res_o
);
  import sc1_pkg::*;

  logic [6:0] key;
  logic [7:0] base_c;
  logic [7:0] shifted_c;
  logic [6:0] base;
  logic [6:0] shifted;
  logic       is_letter;

  // table lookups
  assign key       = scan_byte_i[6:0];
  assign base_c    = plain_char(key);
  assign shifted_c = shift_char(key);
  assign base      = base_c[6:0];
  assign shifted   = shifted_c[6:0];
  assign is_letter = (base >= AsciiLowerA) && (base <= AsciiLowerZ);

  // next state and result
  always_comb begin
    state_o = state_i;
    res_o   = '{valid: 1'b0, kind: EVT_CHAR, code: 7'd0};
    if (scan_byte_i == ScExtPrefix) begin
      state_o.ext = 1'b1;
    end else if (scan_byte_i[7]) begin
      // release: an extended one only drops the prefix
      if (state_i.ext) begin
        state_o.ext = 1'b0;
      end else begin
        if (key == ScLShift || key == ScRShift) state_o.shift = 1'b0;
        if (key == ScCtrl) state_o.ctrl = 1'b0;
        if (key == ScAlt) state_o.alt = 1'b0;
      end
    end else if (state_i.ext) begin
      state_o.ext = 1'b0;
      if (key == ScCursorUp) begin
        res_o = '{valid: 1'b1, kind: EVT_CUR_UP, code: 7'd0};
      end else if (key == ScCursorDown) begin
        res_o = '{valid: 1'b1, kind: EVT_CUR_DOWN, code: 7'd0};
      end
    end else if (key == ScLShift || key == ScRShift) begin
      state_o.shift = 1'b1;
    end else if (key == ScCtrl) begin
      state_o.ctrl = 1'b1;
    end else if (key == ScAlt) begin
      state_o.alt = 1'b1;
    end else if (key == ScCapsLock) begin
      state_o.caps = ~state_i.caps;
    end else if (state_i.ctrl && state_i.alt) begin
      // ctrl+alt chords: only the system-request keys give a result
      unique case (key)
        ScSysDiag:     res_o = '{valid: 1'b1, kind: EVT_SYSREQ, code: ActDiag};
        ScSysIrq:      res_o = '{valid: 1'b1, kind: EVT_SYSREQ, code: ActIrq};
        ScSysKill:     res_o = '{valid: 1'b1, kind: EVT_SYSREQ, code: ActKill};
        ScSysReboot:   res_o = '{valid: 1'b1, kind: EVT_SYSREQ, code: ActReboot};
        ScSysPowerOff: res_o = '{valid: 1'b1, kind: EVT_SYSREQ, code: ActPowerOff};
        default:       res_o = '{valid: 1'b0, kind: EVT_CHAR, code: 7'd0};
      endcase
    end else if (base != 7'd0) begin
      res_o.valid = 1'b1;
      res_o.kind  = EVT_CHAR;
      if (is_letter) begin
        // caps lock flips shift for letters only
        res_o.code = (state_i.shift ^ state_i.caps) ? (base & ~AsciiCaseBit) : base;
      end else begin
        res_o.code = state_i.shift ? shifted : base;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/scancode_set1_to_ascii_decoder_core.sv
// Scancode set 1 to US-layout ASCII decoder. One scancode byte is taken per
// item and can be taken in every cycle unless a stall holds the input
// register. An accepted byte sits in an input register, is decoded against
// the shift, ctrl, alt, caps lock and extended-prefix state, and any result
// lands in the output register. Throughput is one byte per cycle, set by the
// single decode stage, while no stall holds the input register; bytes that
// give no result never wait for the output side, and a stalled output backs
// up into the input register only when the waiting byte has a result. Prefix
// bytes, releases, modifier keys and unmapped keys give no result.
// depends on sc1_pkg, sc1_byte_if, sc1_event_if and sc1_decode
`default_nettype none

module scancode_set1_to_ascii_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  sc1_byte_if.sink    in_i,
  sc1_event_if.source out_o
);
  import sc1_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  mod_state_t state_q;
  mod_state_t state_d;
  dec_res_t   res;
  logic       out_valid_q;
  evt_kind_e  out_kind_q;
  logic [6:0] out_code_q;
  logic       out_free;
  logic       advance;

  sc1_decode u_decode (
    .scan_byte_i (in_byte_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .res_o       (res)
  );

  // handshake: a byte leaves the input register once its result, if any, has a place
  assign out_free  = !out_valid_q || out_o.ready;
  assign advance   = in_valid_q && (!res.valid || out_free);
  assign in_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.scan_byte;
    end
  end

  // modifier state follows every decoded byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && res.valid) begin
      out_kind_q <= res.kind;
      out_code_q <= res.code;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_kind = out_kind_q;
  assign out_o.event_code = out_code_q;

endmodule

`default_nettype wire

>>> rtl/core/sc1_checker.sv
// port-level checks of the scancode decoder and their bind to the top level
// depends on sc1_pkg and the assertion macro header
`default_nettype none
`include "scancode_set1_to_ascii_decoder_core_macros.svh"

module sc1_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic [6:0] out_code_i
);
  import sc1_pkg::*;

  // a stalled item stays offered and unchanged
  `SC1_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `SC1_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_kind_i) && $stable(out_code_i), "result changed while stalled")

  // cursor events carry no code
  `SC1_ASSERT_IMPLY(a_cursor_code, clk_i, rst_ni, out_valid_i && (out_kind_i == EVT_CUR_UP || out_kind_i == EVT_CUR_DOWN), out_code_i == 7'd0, "cursor event with nonzero code")

  // only five system-request actions exist
  `SC1_ASSERT_IMPLY(a_sysreq_code, clk_i, rst_ni, out_valid_i && out_kind_i == EVT_SYSREQ, out_code_i <= ActPowerOff, "unknown system-request action")

  // characters come only from mapped keys
  `SC1_ASSERT_IMPLY(a_char_code, clk_i, rst_ni, out_valid_i && out_kind_i == EVT_CHAR, out_code_i != 7'd0, "character item with null code")

endmodule

bind scancode_set1_to_ascii_decoder_core sc1_checker u_sc1_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.event_kind),
  .out_code_i  (out_o.event_code)
);

`default_nettype wire
